[hdl/lsm_pkg.sv]
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the literal substring matcher
// Item structs, configuration register codes and byte helpers used by the
// configuration registers, the window compare and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

    // Needle storage in the configuration registers, in bytes
    localparam int NEEDLE_BYTES = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int LENGTH_W     = 5;
    localparam int RESULT_W     = 32;

    // ASCII letter folding
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NEEDLE_LOW    = 2'd0,
        CFG_NEEDLE_HIGH   = 2'd1,
        CFG_NEEDLE_LENGTH = 2'd2,
        CFG_FOLD_CASE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic                match_hit;
        logic [RESULT_W-1:0] match_start;
        logic [RESULT_W-1:0] matches_so_far;
        logic                is_final;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] needle_low_word;
        logic [CFG_DATA_W-1:0] needle_high_word;
        logic [LENGTH_W-1:0]   needle_length;
        logic                  fold_case;
    } cfg_t;

    // Map an upper-case ASCII letter to lower case when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // Pick needle byte i out of the two needle words
    function automatic logic [7:0] needle_byte(input cfg_t cfg, input logic [3:0] i);
        logic [7:0] r;
        if (i[3]) begin
            r = cfg.needle_high_word[8*i[2:0] +: 8];
        end else begin
            r = cfg.needle_low_word[8*i[2:0] +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/literal_substring_matcher.sv]
// ----------------------------------------------------------------------------
// literal_substring_matcher: streaming exact substring search
// Reports every leftmost, non-overlapping occurrence of a 1 to 16 byte needle
// in a haystack that arrives one byte per item.
// ----------------------------------------------------------------------------
// The block takes one haystack byte per clock while the result side does not
// stall and returns exactly one result item for each byte. An accepted item is
// held in the input register; the window compare, position and count logic then
// fill the result register when the output side is free, and while it is free a
// new byte is taken in every cycle. The rate rests on the combinational parallel
// compare of up to 16 window bytes.
// Configure the needle words, length and fold mode only while no item is in
// flight; the new setting applies from the next byte. A byte marked buffer_end
// carries the final count and clears the window, position and count.
`default_nettype none

module literal_substring_matcher #(
    parameter int MAX_NEEDLE    = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire lsm_pkg::in_item_t               s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output lsm_pkg::out_item_t                   m_item,
    input  wire logic                            cfg_wr_en,
    input  wire lsm_pkg::cfg_index_t             cfg_index,
    input  wire logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CAP     = (MAX_NEEDLE < lsm_pkg::NEEDLE_BYTES) ? MAX_NEEDLE
                                                                  : lsm_pkg::NEEDLE_BYTES;
    localparam int LEN_W   = $clog2(CAP + 1);
    localparam int START_W = (POSITION_BITS > lsm_pkg::RESULT_W) ? POSITION_BITS
                                                                 : lsm_pkg::RESULT_W;

    lsm_pkg::cfg_t      cfg;
    logic [LEN_W-1:0]   active_len;
    logic [LEN_W-1:0]   len_m1;
    logic               window_hit;

    logic               in_valid_reg, in_valid_next;
    lsm_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg, out_valid_next;
    lsm_pkg::out_item_t out_item_reg, out_item_next;

    logic [POSITION_BITS-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]             ovl_reg, ovl_next;
    logic [lsm_pkg::RESULT_W-1:0] total_reg, total_next, total_upd;

    logic                     advance;
    logic                     blocked;
    logic                     hit;
    logic [POSITION_BITS-1:0] start_full;
    logic [START_W-1:0]       start_ext;

    lsm_cfg_regs #(
        .CAP   (CAP),
        .LEN_W (LEN_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .active_len (active_len)
    );

    lsm_window_match #(
        .CAP   (CAP),
        .LEN_W (LEN_W)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (advance),
        .clear      (in_item_reg.buffer_end),
        .text_byte  (in_item_reg.text_byte),
        .cfg        (cfg),
        .active_len (active_len),
        .window_hit (window_hit)
    );

    // Handshake: move the held item on whenever the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Match decision: no hit while blocked or before a full needle has arrived
    assign len_m1  = active_len - LEN_W'(1);
    assign blocked = (ovl_reg != '0);
    assign hit     = !blocked && (pos_reg >= POSITION_BITS'(len_m1)) && window_hit;

    // Stream state updates
    always_comb begin
        total_upd = total_reg;
        if (hit && (total_reg != '1)) begin
            total_upd = total_reg + lsm_pkg::RESULT_W'(1);
        end

        ovl_next = ovl_reg;
        if (blocked) begin
            ovl_next = ovl_reg - LEN_W'(1);
        end else if (hit) begin
            ovl_next = len_m1;
        end

        pos_next = pos_reg;
        if (pos_reg != '1) begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end

        total_next = total_upd;
        if (in_item_reg.buffer_end) begin
            ovl_next   = '0;
            pos_next   = '0;
            total_next = '0;
        end
    end

    // Result fields
    assign start_full = hit ? (pos_reg - POSITION_BITS'(len_m1)) : '0;
    assign start_ext  = START_W'(start_full);

    always_comb begin
        out_item_next.match_hit      = hit;
        out_item_next.match_start    = start_ext[lsm_pkg::RESULT_W-1:0];
        out_item_next.matches_so_far = total_upd;
        out_item_next.is_final       = in_item_reg.buffer_end;
    end

    // Control and stream registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            ovl_reg       <= '0;
            total_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pos_reg   <= pos_next;
                ovl_reg   <= ovl_next;
                total_reg <= total_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    // A blocked byte never reports a hit
    a_blocked_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (ovl_reg != '0)) |=> !out_item_reg.match_hit)
        else $error("hit reported inside the overlap block-out");

    // A hit that does not end the buffer arms the block-out with len-1
    a_hit_arms_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && hit && !in_item_reg.buffer_end) |=> (ovl_reg == $past(len_m1)))
        else $error("block-out not armed after a hit");

    // A buffer end clears the stream position and count
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.buffer_end) |=> ((pos_reg == '0) && (total_reg == '0)))
        else $error("stream state not cleared at buffer end");

    // An empty result register never stalls the input side
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with result register empty");

endmodule

`default_nettype wire

[hdl/lsm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lsm_cfg_regs: configuration registers of the literal substring matcher
// Holds the needle words, the needle length and the fold mode, and decodes
// the needle length into the length actually compared.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cfg_regs #(
    parameter int CAP   = 16,
    parameter int LEN_W = 5
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire lsm_pkg::cfg_index_t             cfg_index,
    input  wire logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lsm_pkg::cfg_t                        cfg,
    output logic [LEN_W-1:0]                     active_len
);

    lsm_pkg::cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.needle_low_word  <= '0;
            cfg_reg.needle_high_word <= '0;
            cfg_reg.needle_length    <= lsm_pkg::LENGTH_W'(1);
            cfg_reg.fold_case        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lsm_pkg::CFG_NEEDLE_LOW:    cfg_reg.needle_low_word  <= cfg_data;
                lsm_pkg::CFG_NEEDLE_HIGH:   cfg_reg.needle_high_word <= cfg_data;
                lsm_pkg::CFG_NEEDLE_LENGTH:
                    cfg_reg.needle_length <= cfg_data[lsm_pkg::LENGTH_W-1:0];
                lsm_pkg::CFG_FOLD_CASE:     cfg_reg.fold_case <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Clamp the length: zero acts as one, anything past the cap acts as the cap
    always_comb begin
        priority if (cfg_reg.needle_length == '0) begin
            active_len = LEN_W'(1);
        end else if (32'(cfg_reg.needle_length) > CAP) begin
            active_len = LEN_W'(CAP);
        end else begin
            active_len = LEN_W'(cfg_reg.needle_length);
        end
    end

endmodule

`default_nettype wire

[hdl/lsm_window_match.sv]
// ----------------------------------------------------------------------------
// lsm_window_match: byte window and parallel needle compare
// Keeps the most recent haystack bytes, newest first, and compares the
// window with the incoming byte shifted in against the active needle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_window_match #(
    parameter int CAP   = 16,
    parameter int LEN_W = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             shift_en,
    input  wire logic             clear,
    input  wire logic [7:0]       text_byte,
    input  wire lsm_pkg::cfg_t    cfg,
    input  wire logic [LEN_W-1:0] active_len,
    output logic                  window_hit
);

    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    logic [7:0]     window_reg  [CAP];
    logic [7:0]     window_next [CAP];
    logic [CAP-1:0] lane_ok;

    // Shift the incoming byte in at the newest end
    always_comb begin
        window_next[0] = text_byte;
        for (int k = 1; k < CAP; k++) begin
            window_next[k] = window_reg[k-1];
        end
    end

    // Hold the window, advance on each item, drop it at a buffer end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CAP; k++) begin
                window_reg[k] <= '0;
            end
        end else if (shift_en) begin
            for (int k = 0; k < CAP; k++) begin
                window_reg[k] <= clear ? 8'd0 : window_next[k];
            end
        end
    end

    // Compare needle byte i against the byte len-1-i places back
    always_comb begin
        logic [LEN_W-1:0] sel;
        for (int i = 0; i < CAP; i++) begin
            sel = active_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) >= active_len) begin
                lane_ok[i] = 1'b1;
            end else begin
                lane_ok[i] =
                    lsm_pkg::fold_byte(window_next[sel[IDX_W-1:0]], cfg.fold_case) ==
                    lsm_pkg::fold_byte(lsm_pkg::needle_byte(cfg, 4'(i)), cfg.fold_case);
            end
        end
    end

    assign window_hit = &lane_ok;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the literal substring matcher
// Walks a short table of hand-picked haystacks and needle setups, then random
// needle setups with haystacks built mostly from needle pieces. Every result
// item is checked field by field against a pinned or an in-bench predicted result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_GOAL     = 1250;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRESSURE_AT   = 400;
    localparam int PRESSURE_HOLD = 300;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [7:0]  LOWER_A       = 8'h61;
    localparam logic [7:0]  LOWER_Z       = 8'h7A;
    localparam logic [31:0] TEXT_ALPHABET = "abAB";

    typedef enum logic {ROW_SETUP, ROW_BYTE} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [127:0]        needle;
        logic [4:0]          span;
        logic                fold;
        lsm_pkg::in_item_t   item;
        logic                pinned;
        lsm_pkg::out_item_t  result;
    } plan_row_t;

    localparam int PLAN_ROWS = 25;

    // Directed haystacks; pinned rows carry a result typed in by hand
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h00, 1'b0}, 1'b1, '{1'b1, 32'd0, 32'd1, 1'b0}},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'hFF, 1'b1}, 1'b1, '{1'b0, 32'd0, 32'd1, 1'b1}},
        '{ROW_SETUP, 128'h636261, 5'd3, 1'b0, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h62, 1'b0}, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h63, 1'b0}, 1'b1, '{1'b1, 32'd0, 32'd1, 1'b0}},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h62, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h63, 1'b1}, 1'b1, '{1'b1, 32'd3, 32'd2, 1'b1}},
        '{ROW_SETUP, 128'h6161, 5'd2, 1'b0, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b1}, 1'b0, '0},
        '{ROW_SETUP, 128'h5A, 5'd0, 1'b1, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h7A, 1'b0}, 1'b1, '{1'b1, 32'd0, 32'd1, 1'b0}},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h5B, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h60, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h5A, 1'b1}, 1'b1, '{1'b1, 32'd3, 32'd2, 1'b1}},
        '{ROW_SETUP, 128'h6261, 5'd2, 1'b0, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h61, 1'b0}, 1'b0, '0},
        '{ROW_SETUP, 128'h6241, 5'd2, 1'b1, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'h42, 1'b1}, 1'b0, '0},
        '{ROW_SETUP, {16{8'hFF}}, 5'd31, 1'b1, '{8'h00, 1'b0}, 1'b0, '0},
        '{ROW_BYTE,  128'h0, 5'd0, 1'b0, '{8'hFF, 1'b1}, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b1}}
    };

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lsm_pkg::in_item_t              s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lsm_pkg::out_item_t             m_item;
    logic                           cfg_wr_en = 1'b0;
    lsm_pkg::cfg_index_t            cfg_index = lsm_pkg::CFG_NEEDLE_LOW;
    logic [lsm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and the stream state
    logic [127:0] needle_model = '0;
    logic [4:0]   length_model = 5'd1;
    logic         fold_model   = 1'b0;
    logic [7:0]   window_bytes [lsm_pkg::NEEDLE_BYTES];
    logic [31:0]  position     = '0;
    logic [4:0]   block_left   = '0;
    logic [31:0]  hit_total    = '0;

    lsm_pkg::out_item_t expected_results [$];
    int unsigned  bytes_fed     = 0;
    int unsigned  results_seen  = 0;
    int unsigned  hits_seen     = 0;
    int unsigned  ends_seen     = 0;
    int unsigned  setups_done   = 0;
    int unsigned  mismatches    = 0;
    int unsigned  quiet_cycles  = 0;
    bit           tx_steady     = 1'b0;
    bit           rx_steady     = 1'b0;
    bit           pressure_done = 1'b0;

    literal_substring_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        foreach (window_bytes[k]) window_bytes[k] = '0;
    end

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (fold_model && (c >= lsm_pkg::ASCII_UPPER_A) && (c <= lsm_pkg::ASCII_UPPER_Z)) begin
            return c + lsm_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    // Length register as the compare sees it: zero acts as one, cap at 16
    function automatic int active_span(input logic [4:0] n);
        if (n == 0) return 1;
        if (n > lsm_pkg::NEEDLE_BYTES) return lsm_pkg::NEEDLE_BYTES;
        return int'(n);
    endfunction

    // Advance the stream state by one byte and return the result item it causes
    function automatic lsm_pkg::out_item_t predict_match(input lsm_pkg::in_item_t it);
        lsm_pkg::out_item_t r;
        int                 span;
        bit                 same;
        span = active_span(length_model);
        for (int k = lsm_pkg::NEEDLE_BYTES - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = it.text_byte;
        r = '0;
        if (block_left != 0) begin
            block_left--;
        end else if (position >= 32'(span - 1)) begin
            same = 1'b1;
            for (int k = 0; k < span; k++) begin
                if (lower_ascii(window_bytes[span-1-k]) != lower_ascii(needle_model[8*k +: 8]))
                    same = 1'b0;
            end
            if (same) begin
                r.match_hit   = 1'b1;
                r.match_start = position - 32'(span - 1);
                block_left    = 5'(span - 1);
                if (hit_total != '1) hit_total++;
            end
        end
        if (position != '1) position++;
        r.matches_so_far = hit_total;
        r.is_final       = it.buffer_end;
        // Drop all stream state at the end of the haystack
        if (it.buffer_end) begin
            foreach (window_bytes[k]) window_bytes[k] = '0;
            position   = '0;
            block_left = '0;
            hit_total  = '0;
        end
        return r;
    endfunction

    // Write all four registers once the block has drained
    task automatic load_setup(input logic [127:0] needle, input logic [4:0] span,
                              input logic fold);
        logic [63:0] filler;
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= lsm_pkg::CFG_NEEDLE_LOW;
        cfg_data  <= needle[63:0];
        @(posedge aclk);
        cfg_index <= lsm_pkg::CFG_NEEDLE_HIGH;
        cfg_data  <= needle[127:64];
        @(posedge aclk);
        filler      = {$urandom(), $urandom()};
        filler[4:0] = span;
        cfg_index <= lsm_pkg::CFG_NEEDLE_LENGTH;
        cfg_data  <= filler;
        @(posedge aclk);
        filler    = {$urandom(), $urandom()};
        filler[0] = fold;
        cfg_index <= lsm_pkg::CFG_FOLD_CASE;
        cfg_data  <= filler;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        needle_model = needle;
        length_model = span;
        fold_model   = fold;
        setups_done++;
    endtask

    // Offer one byte, hold it until accepted, then record what it should produce
    task automatic send_item(input lsm_pkg::in_item_t it, input bit pinned,
                             input lsm_pkg::out_item_t pinned_res);
        int unsigned        gap;
        lsm_pkg::out_item_t guess;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        guess = predict_match(it);
        expected_results.push_back(pinned ? pinned_res : guess);
        bytes_fed++;
    endtask

    // Stimulus: reset, directed table, then random needle setups and haystacks
    initial begin : stimulus
        logic [127:0]      needle;
        logic [4:0]        span_reg;
        logic              fold;
        int                span;
        int                phase_left;
        int                cut;
        int unsigned       pick;
        logic [7:0]        b;
        logic [7:0]        burst [$];
        lsm_pkg::in_item_t nxt;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_SETUP) begin
                load_setup(DIRECTED_PLAN[i].needle, DIRECTED_PLAN[i].span,
                           DIRECTED_PLAN[i].fold);
            end else begin
                send_item(DIRECTED_PLAN[i].item, DIRECTED_PLAN[i].pinned,
                          DIRECTED_PLAN[i].result);
            end
        end

        while (bytes_fed < ITEM_GOAL) begin
            // Pick a length, mostly short, with the capped and zero values now and then
            pick = $urandom_range(0, 19);
            if (pick < 14)       span_reg = 5'($urandom_range(1, 6));
            else if (pick < 16)  span_reg = 5'd16;
            else if (pick < 18)  span_reg = 5'($urandom_range(7, 15));
            else if (pick == 18) span_reg = 5'd0;
            else                 span_reg = 5'($urandom_range(17, 31));
            for (int k = 0; k < lsm_pkg::NEEDLE_BYTES; k++) begin
                if ($urandom_range(0, 4) < 3)
                    needle[8*k +: 8] = TEXT_ALPHABET[8*$urandom_range(0, 3) +: 8];
                else
                    needle[8*k +: 8] = 8'($urandom_range(0, 255));
            end
            fold = 1'($urandom_range(0, 1));
            load_setup(needle, span_reg, fold);
            span = active_span(span_reg);
            tx_steady = ($urandom_range(0, 3) == 0);

            phase_left = $urandom_range(30, 90);
            while (phase_left > 0) begin
                burst.delete();
                if ($urandom_range(0, 9) < 5) begin
                    // Splice in the needle, sometimes cut short, letters case-flipped at random when folding
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span) : span;
                    for (int k = 0; k < cut; k++) begin
                        b = needle[8*k +: 8];
                        if (fold && ((b | lsm_pkg::CASE_OFFSET) >= LOWER_A)
                                 && ((b | lsm_pkg::CASE_OFFSET) <= LOWER_Z)
                                 && $urandom_range(0, 1))
                            b = b ^ lsm_pkg::CASE_OFFSET;
                        burst.push_back(b);
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 9) < 7)
                            burst.push_back(needle[8*$urandom_range(0, span - 1) +: 8]);
                        else
                            burst.push_back(8'($urandom_range(0, 255)));
                    end
                end
                foreach (burst[k]) begin
                    nxt.text_byte  = burst[k];
                    nxt.buffer_end = ($urandom_range(0, 39) == 0);
                    send_item(nxt, 1'b0, '0);
                    phase_left--;
                end
            end
        end

        // Drain, then let the bench settle
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("testbench: %0d bytes over %0d needle setups, %0d results checked",
                 bytes_fed, setups_done, results_seen);
        $display("testbench: %0d matches reported, %0d haystacks ended, %0d mismatches",
                 hits_seen, ends_seen, mismatches);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, compare against the oldest expectation
    initial begin : result_check
        int unsigned        hold;
        lsm_pkg::out_item_t want;
        bit                 bad;
        wait (aresetn === 1'b1);
        forever begin
            if (results_seen % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            hold = rx_steady ? 0 : $urandom_range(0, 15);
            // Hold off long while the sender is busy so the block fills and stalls
            if (!pressure_done && (results_seen >= PRESSURE_AT) && s_valid) begin
                hold          = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (m_item.match_hit) hits_seen++;
            if (m_item.is_final) ends_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("testbench: result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_results.pop_front();
                bad = (m_item.match_hit !== want.match_hit)
                   || (m_item.match_start !== want.match_start)
                   || (m_item.matches_so_far !== want.matches_so_far)
                   || (m_item.is_final !== want.is_final);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("testbench: result %0d exp hit %0b start %0d count %0d end %0b",
                                 results_seen, want.match_hit, want.match_start,
                                 want.matches_so_far, want.is_final);
                        $display("testbench: result %0d got hit %0b start %0d count %0d end %0b",
                                 results_seen, m_item.match_hit, m_item.match_start,
                                 m_item.matches_so_far, m_item.is_final);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: no progress for %0d cycles", STALL_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

endmodule

[files.f]
hdl/lsm_pkg.sv
hdl/lsm_cfg_regs.sv
hdl/lsm_window_match.sv
hdl/literal_substring_matcher.sv
bench/testbench.sv
